// ----- rtl/core/pmes_pkg.sv -----
// Shared types, constants and saturation helpers for the point-mass integrator.
// No dependencies; used by the lane, merge and top-level modules.
package pmes_pkg;

  localparam int VAL_W  = 32;               // Q16.16 values
  localparam int POS_W  = 48;               // Q32.16 position
  localparam int FRAC_W = 16;
  localparam int DT_W   = 16;               // unsigned Q0.16 step
  localparam int FSUM_W = VAL_W + 1;        // thrust + drag, exact
  localparam int OP_W   = VAL_W + 1;        // multiplier operand width
  localparam int PROD_W = 2 * VAL_W + 1;    // widest product kept
  localparam int SH_W   = PROD_W - FRAC_W;  // product after the Q shift
  localparam int SUM_W  = POS_W + 2;        // accumulate before saturation
  localparam int NLANES = 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    P_FORCE,
    P_ACC,
    P_ADT,
    P_VEL,
    P_VDT,
    P_POS
  } phase_t;

  typedef enum logic {
    CFG_INV_MASS  = 1'b0,
    CFG_TIME_STEP = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic   capture;  // latch step operands
    logic   load;     // load initial position and velocity
    logic   run;      // sequencer active
    phase_t phase;
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] vel;
    logic signed [VAL_W-1:0] acc;
  } lane_res_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (&v[SUM_W-1:VAL_W-1] || ~|v[SUM_W-1:VAL_W-1]) begin
      r = v[VAL_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (&v[SUM_W-1:POS_W-1] || ~|v[SUM_W-1:POS_W-1]) begin
      r = v[POS_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/pmes_lane.sv -----
// One axis of the integrator: state registers and a shared multiplier
// sequenced through force, velocity and position updates. Uses pmes_pkg.
module pmes_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  pmes_pkg::lane_ctrl_t                ctrl,
  input  logic signed [pmes_pkg::VAL_W-1:0]   vec_a,
  input  logic signed [pmes_pkg::VAL_W-1:0]   vec_b,
  input  logic signed [pmes_pkg::VAL_W-1:0]   drag,
  input  logic        [pmes_pkg::VAL_W-1:0]   inverse_mass,
  input  logic        [pmes_pkg::DT_W-1:0]    time_step,
  output pmes_pkg::lane_res_t                 res
);

  logic signed [pmes_pkg::POS_W-1:0]    pos;
  logic signed [pmes_pkg::VAL_W-1:0]    vel;
  logic signed [pmes_pkg::VAL_W-1:0]    acc;
  logic signed [pmes_pkg::FSUM_W-1:0]   fsum;
  logic signed [pmes_pkg::VAL_W-1:0]    grav;
  logic signed [pmes_pkg::PROD_W-1:0]   prod;

  logic signed [pmes_pkg::OP_W-1:0]     op_a;
  logic signed [pmes_pkg::OP_W-1:0]     op_b;
  logic signed [2*pmes_pkg::OP_W-1:0]   full;
  logic signed [pmes_pkg::SH_W-1:0]     sh;
  logic signed [pmes_pkg::SUM_W-1:0]    acc_sum;
  logic signed [pmes_pkg::SUM_W-1:0]    vel_sum;
  logic signed [pmes_pkg::SUM_W-1:0]    pos_sum;
  logic                                 mul_en;

  always_comb begin
    case (ctrl.phase)
      pmes_pkg::P_FORCE: begin
        op_a = fsum;
        op_b = {1'b0, inverse_mass};
      end
      pmes_pkg::P_ADT: begin
        op_a = {acc[pmes_pkg::VAL_W-1], acc};
        op_b = {{(pmes_pkg::OP_W-pmes_pkg::DT_W){1'b0}}, time_step};
      end
      pmes_pkg::P_VDT: begin
        op_a = {vel[pmes_pkg::VAL_W-1], vel};
        op_b = {{(pmes_pkg::OP_W-pmes_pkg::DT_W){1'b0}}, time_step};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign full   = op_a * op_b;
  assign mul_en = ctrl.run && (ctrl.phase == pmes_pkg::P_FORCE ||
                               ctrl.phase == pmes_pkg::P_ADT ||
                               ctrl.phase == pmes_pkg::P_VDT);

  // dropping the fraction bits of a signed product rounds toward minus infinity
  assign sh = prod[pmes_pkg::PROD_W-1:pmes_pkg::FRAC_W];

  assign acc_sum = {{(pmes_pkg::SUM_W-pmes_pkg::VAL_W){grav[pmes_pkg::VAL_W-1]}}, grav}
                 + {{(pmes_pkg::SUM_W-pmes_pkg::SH_W){sh[pmes_pkg::SH_W-1]}}, sh};
  assign vel_sum = {{(pmes_pkg::SUM_W-pmes_pkg::VAL_W){vel[pmes_pkg::VAL_W-1]}}, vel}
                 + {{(pmes_pkg::SUM_W-pmes_pkg::SH_W){sh[pmes_pkg::SH_W-1]}}, sh};
  assign pos_sum = {{(pmes_pkg::SUM_W-pmes_pkg::POS_W){pos[pmes_pkg::POS_W-1]}}, pos}
                 + {{(pmes_pkg::SUM_W-pmes_pkg::SH_W){sh[pmes_pkg::SH_W-1]}}, sh};

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      fsum <= {vec_a[pmes_pkg::VAL_W-1], vec_a} + {drag[pmes_pkg::VAL_W-1], drag};
      grav <= vec_b;
    end
    if (mul_en) begin
      prod <= full[pmes_pkg::PROD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      vel <= '0;
      acc <= '0;
    end else if (ctrl.load) begin
      pos <= {{(pmes_pkg::POS_W-pmes_pkg::VAL_W){vec_a[pmes_pkg::VAL_W-1]}}, vec_a};
      vel <= vec_b;
      acc <= '0;
    end else if (ctrl.run) begin
      case (ctrl.phase)
        pmes_pkg::P_ACC: acc <= pmes_pkg::sat_val(acc_sum);
        pmes_pkg::P_VEL: vel <= pmes_pkg::sat_val(vel_sum);
        pmes_pkg::P_POS: pos <= pmes_pkg::sat_pos(pos_sum);
        default: ;
      endcase
    end
  end

  assign res.pos = pos;
  assign res.vel = vel;
  assign res.acc = acc;

endmodule

// ----- rtl/core/pmes_merge.sv -----
// Merge stage: gathers the three lane results and the step count into the
// output register and runs the output handshake. Uses pmes_pkg.
module pmes_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  pmes_pkg::lane_res_t           lane_res [pmes_pkg::NLANES],
  input  logic [pmes_pkg::VAL_W-1:0]    steps,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          free,
  output pmes_pkg::lane_res_t           res_q [pmes_pkg::NLANES],
  output logic [pmes_pkg::VAL_W-1:0]    steps_q
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < pmes_pkg::NLANES; i++) begin
        res_q[i] <= lane_res[i];
      end
      steps_q <= steps;
    end
  end

endmodule

// ----- rtl/core/point_mass_euler_step_top.sv -----
// Three-axis symplectic Euler point-mass integrator, signed fixed point.
// Depends on pmes_pkg, pmes_lane and pmes_merge.
//
// Input channel (in_valid / in_stall): one request per item. opcode 0 steps
// the state with thrust (vec_a_*), gravity (vec_b_*) and drag (drag_*);
// opcode 1 loads position from vec_a_* and velocity from vec_b_*, clears
// acceleration and zeroes the step count.
// Output channel (out_valid / out_stall): one result per request carrying
// position, velocity, acceleration and step count after that request.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 writes
// inverse_mass, index 1 writes time_step. Write only while idle.
// A step request goes from accept through the force, acceleration, velocity
// and position phases of each lane's shared multiplier and accumulator to
// the merge; a load request goes straight to the merge. Result appears on
// out_valid the cycle after the merge. Three lanes run the axes in parallel.
// Reset: synchronous, clears state to zero, inverse_mass to 1.0, time_step
// to 655. A stalled result is held in the output register; the next request
// is still taken and finishes up to the merge, then waits for the register.
module point_mass_euler_step_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [0:0]         opcode,
  input  logic signed [31:0] vec_a_x,
  input  logic signed [31:0] vec_a_y,
  input  logic signed [31:0] vec_a_z,
  input  logic signed [31:0] vec_b_x,
  input  logic signed [31:0] vec_b_y,
  input  logic signed [31:0] vec_b_z,
  input  logic signed [31:0] drag_x,
  input  logic signed [31:0] drag_y,
  input  logic signed [31:0] drag_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_y,
  output logic signed [47:0] pos_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z,
  output logic signed [31:0] acc_x,
  output logic signed [31:0] acc_y,
  output logic signed [31:0] acc_z,
  output logic [31:0]        steps_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  pmes_pkg::state_t              state;
  pmes_pkg::state_t              state_next;
  pmes_pkg::phase_t              phase;
  pmes_pkg::phase_t              phase_next;
  logic [pmes_pkg::VAL_W-1:0]    inverse_mass;
  logic [pmes_pkg::DT_W-1:0]     time_step;
  logic [pmes_pkg::VAL_W-1:0]    steps;

  logic                          accept;
  logic                          is_load;
  logic                          out_load;
  logic                          free;
  pmes_pkg::lane_ctrl_t          ctrl;
  pmes_pkg::lane_res_t           lane_res [pmes_pkg::NLANES];
  pmes_pkg::lane_res_t           res_q [pmes_pkg::NLANES];
  logic signed [31:0]            va [pmes_pkg::NLANES];
  logic signed [31:0]            vb [pmes_pkg::NLANES];
  logic signed [31:0]            vd [pmes_pkg::NLANES];

  assign accept    = in_valid && !in_stall;
  assign is_load   = opcode[0];
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    phase_next = phase;
    case (state)
      pmes_pkg::S_IDLE: begin
        phase_next = pmes_pkg::P_FORCE;
        if (accept) begin
          state_next = is_load ? pmes_pkg::S_DONE : pmes_pkg::S_RUN;
        end
      end
      pmes_pkg::S_RUN: begin
        if (phase == pmes_pkg::P_POS) begin
          state_next = pmes_pkg::S_DONE;
          phase_next = pmes_pkg::P_FORCE;
        end else begin
          phase_next = pmes_pkg::phase_t'(phase + 3'd1);
        end
      end
      pmes_pkg::S_DONE: begin
        if (free) begin
          state_next = pmes_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pmes_pkg::S_IDLE;
        phase_next = pmes_pkg::P_FORCE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall     = (state != pmes_pkg::S_IDLE);
    out_load     = (state == pmes_pkg::S_DONE) && free;
    ctrl.capture = accept && !is_load;
    ctrl.load    = accept && is_load;
    ctrl.run     = (state == pmes_pkg::S_RUN);
    ctrl.phase   = phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmes_pkg::S_IDLE;
      phase <= pmes_pkg::P_FORCE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mass <= 32'd65536;
      time_step    <= 16'd655;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pmes_pkg::CFG_INV_MASS:  inverse_mass <= cfg_data;
        pmes_pkg::CFG_TIME_STEP: time_step    <= cfg_data[pmes_pkg::DT_W-1:0];
        default: ;
      endcase
    end
  end

  // step count wraps
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (accept) begin
      steps <= is_load ? '0 : steps + 1'b1;
    end
  end

  assign va[0] = vec_a_x;
  assign va[1] = vec_a_y;
  assign va[2] = vec_a_z;
  assign vb[0] = vec_b_x;
  assign vb[1] = vec_b_y;
  assign vb[2] = vec_b_z;
  assign vd[0] = drag_x;
  assign vd[1] = drag_y;
  assign vd[2] = drag_z;

  for (genvar g = 0; g < pmes_pkg::NLANES; g++) begin : g_lane
    pmes_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .vec_a        (va[g]),
      .vec_b        (vb[g]),
      .drag         (vd[g]),
      .inverse_mass (inverse_mass),
      .time_step    (time_step),
      .res          (lane_res[g])
    );
  end

  pmes_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .lane_res  (lane_res),
    .steps     (steps),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (free),
    .res_q     (res_q),
    .steps_q   (steps_done)
  );

  assign pos_x = res_q[0].pos;
  assign pos_y = res_q[1].pos;
  assign pos_z = res_q[2].pos;
  assign vel_x = res_q[0].vel;
  assign vel_y = res_q[1].vel;
  assign vel_z = res_q[2].vel;
  assign acc_x = res_q[0].acc;
  assign acc_y = res_q[1].acc;
  assign acc_z = res_q[2].acc;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != pmes_pkg::S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_load_clears_count: assert property (@(posedge clk) disable iff (rst)
    (accept && is_load) |=> steps == '0)
    else $error("load request did not clear step count");

  a_merge_sets_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("merged result not presented");

  a_run_ends_in_merge: assert property (@(posedge clk) disable iff (rst)
    (state == pmes_pkg::S_RUN && phase == pmes_pkg::P_POS) |=> state == pmes_pkg::S_DONE)
    else $error("position update not followed by merge");

endmodule
